// ----- rtl/core/wa_pkg.sv -----
package wa_pkg;

    localparam int WINDOW_POINTS = 90;
    localparam int WA_AW         = $clog2(WINDOW_POINTS);
    localparam int WA_CW         = $clog2(WINDOW_POINTS + 1);

    localparam int SAMPLE_W = 16;
    localparam int TICK_W   = 13;
    localparam int AXIS_W   = 17;
    localparam int SPAN_W   = 17;
    localparam int DIV_STEPS = SAMPLE_W;
    localparam int DIV_CW    = $clog2(DIV_STEPS);

    localparam int TICK_CHOICES = 8;
    localparam logic [TICK_W-1:0] TICK_FALLBACK = 13'd5;
    localparam logic [TICK_W-1:0] TICK_TABLE [TICK_CHOICES] = '{
        13'd5, 13'd10, 13'd25, 13'd50, 13'd250, 13'd500, 13'd2500, 13'd5000
    };

    typedef enum logic [3:0] {
        S_IDLE,
        S_FILL,
        S_SCAN,
        S_TICK,
        S_DIVS,
        S_DIV,
        S_MUL,
        S_FIN,
        S_OUT
    } t_state;

    // span/5 < t holds exactly when span < 5*t, so no divide is needed here
    function automatic logic [TICK_W-1:0] wa_pick_tick(input logic [SPAN_W-1:0] span);
        logic [TICK_W-1:0] tick;
        logic              found;
        logic [SPAN_W-1:0] limit;
        tick  = TICK_FALLBACK;
        found = 1'b0;
        for (int i = 0; i < TICK_CHOICES; i++) begin
            limit = ({4'd0, TICK_TABLE[i]} << 2) + {4'd0, TICK_TABLE[i]};
            if (!found && span < limit) begin
                tick  = TICK_TABLE[i];
                found = 1'b1;
            end
        end
        return tick;
    endfunction

endpackage

// ----- rtl/core/wa_ram.sv -----
module wa_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 90
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

// ----- rtl/core/wa_div.sv -----
module wa_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [wa_pkg::SAMPLE_W-1:0]  i_dividend,
    input  logic [wa_pkg::TICK_W-1:0]    i_divisor,
    output logic                         o_done,
    output logic [wa_pkg::SAMPLE_W-1:0]  o_quot
);
    import wa_pkg::*;

    logic                r_busy, n_busy;
    logic                r_done, n_done;
    logic [DIV_CW-1:0]   r_cnt, n_cnt;
    logic [TICK_W-1:0]   r_rem, n_rem;
    logic [SAMPLE_W-1:0] r_quo, n_quo;
    logic [TICK_W-1:0]   r_dvs, n_dvs;
    logic [TICK_W:0]     rem_sh;

    // restoring divide, one quotient bit per cycle
    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_dvs  = r_dvs;
        rem_sh = {r_rem, r_quo[SAMPLE_W-1]};
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_rem  = '0;
            n_quo  = i_dividend;
            n_dvs  = i_divisor;
        end else if (r_busy) begin
            if (rem_sh >= {1'b0, r_dvs}) begin
                n_rem = TICK_W'(rem_sh - {1'b0, r_dvs});
                n_quo = {r_quo[SAMPLE_W-2:0], 1'b1};
            end else begin
                n_rem = rem_sh[TICK_W-1:0];
                n_quo = {r_quo[SAMPLE_W-2:0], 1'b0};
            end
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == DIV_CW'(DIV_STEPS - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_dvs <= n_dvs;
    end

    assign o_done = r_done;
    assign o_quot = r_quo;

endmodule

// ----- rtl/core/window_autoscale_axis.sv -----
// Channel   Dir  Width  Contents
// s_axis    in   16     altitude_sample
// m_axis    out  80     window_min, window_max, tick_step, axis_min, axis_max
//
// One item at a time: ready only while the sequencer is idle.
// Normal item: the window scan (one RAM read a cycle) and the 16-step shared
// divider set the time to the result and between items.
// First item after reset: the window is filled, one entry a cycle, the tick is
// the fallback and the divide follows.
// Reset is synchronous, active low; window contents need none. A result held in
// the output register stalls the next item only at its output step.
module window_autoscale_axis (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [15:0] altitude_sample
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [15:0] window_min, [31:16] window_max, [44:32] tick_step,
    // [61:45] axis_min, [78:62] axis_max, [79] zero
    output logic [79:0] m_axis_tdata
);
    import wa_pkg::*;

    t_state r_state, n_state;

    logic                       r_primed, n_primed;
    logic [WA_AW-1:0]           r_wptr, n_wptr;
    logic [WA_CW-1:0]           r_addr, n_addr;
    logic                       r_rd_vld, n_rd_vld;
    logic signed [SAMPLE_W-1:0] r_sample, n_sample;
    logic signed [SAMPLE_W-1:0] r_min, n_min;
    logic signed [SAMPLE_W-1:0] r_max, n_max;
    logic [TICK_W-1:0]          r_tick, n_tick;
    logic [AXIS_W-1:0]          r_prod, n_prod;
    logic signed [AXIS_W-1:0]   r_amin, n_amin;
    logic signed [AXIS_W-1:0]   r_amax, n_amax;
    logic                       r_ovalid, n_ovalid;
    logic [79:0]                r_odata, n_odata;

    logic                       ram_we;
    logic [WA_AW-1:0]           ram_waddr;
    logic                       ram_re;
    logic [SAMPLE_W-1:0]        ram_rdata;
    logic signed [SAMPLE_W-1:0] rd_val;
    logic                       div_start;
    logic                       div_done;
    logic [SAMPLE_W-1:0]        div_quot;
    logic [SAMPLE_W-1:0]        min_mag;
    logic [SPAN_W-1:0]          span;
    logic [SAMPLE_W+TICK_W-1:0] prod_full;
    logic signed [AXIS_W-1:0]   trunc_val;
    logic signed [AXIS_W-1:0]   amin_c;
    logic [AXIS_W-1:0]          five_tick;
    logic                       in_acc;
    logic                       out_free;

    wa_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (WINDOW_POINTS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (r_sample),
        .i_re    (ram_re),
        .i_raddr (r_addr[WA_AW-1:0]),
        .o_rdata (ram_rdata)
    );

    wa_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (min_mag),
        .i_divisor  (r_tick),
        .o_done     (div_done),
        .o_quot     (div_quot)
    );

    assign s_axis_tready = (r_state == S_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_ovalid || m_axis_tready;
    assign rd_val        = signed'(ram_rdata);
    assign min_mag       = r_min[SAMPLE_W-1] ? SAMPLE_W'(~r_min + 1'b1) : r_min;
    assign span          = SPAN_W'({r_max[SAMPLE_W-1], r_max} - {r_min[SAMPLE_W-1], r_min});
    assign prod_full     = div_quot * r_tick;
    assign five_tick     = ({4'd0, r_tick} << 2) + {4'd0, r_tick};
    // quotient is formed on the magnitude, so this truncates toward zero
    assign trunc_val     = r_min[SAMPLE_W-1] ? -signed'(r_prod) : signed'(r_prod);
    assign amin_c        = trunc_val - signed'({4'd0, r_tick});

    always_comb begin
        n_state   = r_state;
        n_primed  = r_primed;
        n_wptr    = r_wptr;
        n_addr    = r_addr;
        n_rd_vld  = 1'b0;
        n_sample  = r_sample;
        n_min     = r_min;
        n_max     = r_max;
        n_tick    = r_tick;
        n_prod    = r_prod;
        n_amin    = r_amin;
        n_amax    = r_amax;
        n_ovalid  = r_ovalid && !m_axis_tready;
        n_odata   = r_odata;
        ram_we    = 1'b0;
        ram_waddr = r_wptr;
        ram_re    = 1'b0;
        div_start = 1'b0;

        // min/max update comes in the cycle after the read
        if (r_rd_vld) begin
            if (rd_val < r_min) n_min = rd_val;
            if (rd_val > r_max) n_max = rd_val;
        end

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_sample = signed'(s_axis_tdata);
                    n_addr   = '0;
                    if (r_primed) begin
                        n_min   = 16'sh7fff;
                        n_max   = -16'sh8000;
                        n_state = S_SCAN;
                    end else begin
                        n_state = S_FILL;
                    end
                end
            end
            S_FILL: begin
                ram_we    = 1'b1;
                ram_waddr = r_addr[WA_AW-1:0];
                n_addr    = r_addr + 1'b1;
                if (r_addr == WA_CW'(WINDOW_POINTS - 1)) begin
                    // entry 0 already holds the sample, so the pointer moves on
                    n_primed = 1'b1;
                    n_wptr   = WA_AW'(1);
                    n_min    = r_sample;
                    n_max    = r_sample;
                    n_tick   = TICK_FALLBACK;
                    n_state  = S_DIVS;
                end
            end
            S_SCAN: begin
                if (r_addr != WA_CW'(WINDOW_POINTS)) begin
                    ram_re   = 1'b1;
                    n_rd_vld = 1'b1;
                    n_addr   = r_addr + 1'b1;
                end else if (!r_rd_vld) begin
                    n_state = S_TICK;
                end
            end
            S_TICK: begin
                ram_we  = 1'b1;
                n_wptr  = (r_wptr == WA_AW'(WINDOW_POINTS - 1)) ? '0 : r_wptr + 1'b1;
                n_tick  = wa_pick_tick(span);
                n_state = S_DIVS;
            end
            S_DIVS: begin
                div_start = 1'b1;
                n_state   = S_DIV;
            end
            S_DIV: begin
                if (div_done) begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                n_prod  = prod_full[AXIS_W-1:0];
                n_state = S_FIN;
            end
            S_FIN: begin
                n_amin  = amin_c;
                n_amax  = amin_c + signed'(five_tick);
                n_state = S_OUT;
            end
            S_OUT: begin
                if (out_free) begin
                    n_ovalid = 1'b1;
                    n_odata  = {1'b0, r_amax, r_amin, r_tick, r_max, r_min};
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_primed <= 1'b0;
            r_wptr   <= '0;
            r_addr   <= '0;
            r_rd_vld <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_primed <= n_primed;
            r_wptr   <= n_wptr;
            r_addr   <= n_addr;
            r_rd_vld <= n_rd_vld;
            r_ovalid <= n_ovalid;
        end
        r_sample <= n_sample;
        r_min    <= n_min;
        r_max    <= n_max;
        r_tick   <= n_tick;
        r_prod   <= n_prod;
        r_amin   <= n_amin;
        r_amax   <= n_amax;
        r_odata  <= n_odata;
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;

    a_div_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> r_state == S_DIV)
        else $error("divider finished outside its wait state");

    a_rd_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_vld |-> r_state == S_SCAN)
        else $error("window read data arrived outside the scan");

    a_primed_stays: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$fell(r_primed))
        else $error("window lost its primed mark");

    a_axis_span: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid |-> (r_odata[78:62] - r_odata[61:45]) ==
                     (({4'd0, r_odata[44:32]} << 2) + {4'd0, r_odata[44:32]}))
        else $error("axis bounds are not five ticks apart");

    a_window_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid |-> signed'(r_odata[15:0]) <= signed'(r_odata[31:16]))
        else $error("window minimum above maximum");

endmodule

// ----- tb/tb_window_autoscale_axis.sv -----
`timescale 1ns / 100ps

module tb_window_autoscale_axis;
    import wa_pkg::*;

    localparam int CLK_HALF     = 4;
    localparam int RANDOM_ITEMS = 900;
    localparam int HOLD_OFF     = 1500;
    // run limit, set with a wide margin over the slowest correct run
    localparam int CYCLE_LIMIT  = 600000;
    localparam int DIR_ROWS     = 18;

    typedef struct packed {
        logic signed [AXIS_W-1:0]   axis_max;
        logic signed [AXIS_W-1:0]   axis_min;
        logic [TICK_W-1:0]          tick_step;
        logic signed [SAMPLE_W-1:0] window_max;
        logic signed [SAMPLE_W-1:0] window_min;
    } t_axis_scale;

    typedef struct packed {
        logic                       checked;
        logic signed [SAMPLE_W-1:0] alt;
        t_axis_scale                want;
    } t_dir_row;

    // window of one sample (-7): min toward zero gives -5, less one tick
    localparam t_axis_scale ONLY_NEG7 = '{axis_max: 17'sd15, axis_min: -17'sd10,
        tick_step: 13'd5, window_max: -16'sd7, window_min: -16'sd7};

    t_dir_row dir_tab [DIR_ROWS] = '{
        '{1'b1, -16'sd7, ONLY_NEG7},     // first item fills the window
        '{1'b1, 16'sd3, ONLY_NEG7},      // window still all -7
        '{1'b0, 16'sd130, '0},
        '{1'b0, -16'sd129, '0},
        '{1'b0, 16'sd1250, '0},
        '{1'b0, -16'sd1251, '0},
        '{1'b0, 16'sd12500, '0},
        '{1'b0, -16'sd12500, '0},
        '{1'b0, 16'sd32767, '0},
        '{1'b0, -16'sd32768, '0},
        '{1'b0, 16'sd21845, '0},
        '{1'b0, -16'sd21846, '0},
        '{1'b0, 16'sd0, '0},
        '{1'b0, -16'sd1, '0},
        '{1'b0, 16'sd1, '0},
        '{1'b0, 16'sd24999, '0},
        '{1'b0, -16'sd5000, '0},
        '{1'b0, 16'sd5000, '0}
    };

    int nice_ticks [8] = '{5, 10, 25, 50, 250, 500, 2500, 5000};
    // spans where the tick choice changes (five times each tick)
    int span_steps [8] = '{25, 50, 125, 250, 1250, 2500, 12500, 25000};

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic [15:0] s_axis_tdata = '0;    // [15:0] altitude_sample
    logic        m_axis_tready = 1'b0;
    wire         s_axis_tready;
    wire         m_axis_tvalid;
    // [15:0] window_min, [31:16] window_max, [44:32] tick_step,
    // [61:45] axis_min, [78:62] axis_max, [79] zero
    wire  [79:0] m_axis_tdata;

    logic signed [SAMPLE_W-1:0] alt_window [WINDOW_POINTS];
    bit          window_filled = 1'b0;
    int          wr_idx = 0;
    t_axis_scale expected_scales [$];
    int          results_seen = 0;
    int          mismatches = 0;
    int          cycle_count = 0;

    window_autoscale_axis dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #CLK_HALF i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("window_autoscale_axis test failed");
            $finish;
        end
    end

    // statistics come from the window as it stands before the new sample enters
    function automatic t_axis_scale predict_axis(input logic signed [SAMPLE_W-1:0] alt);
        t_axis_scale r;
        int          lo;
        int          hi;
        int          fifth;
        int          tick;
        int          amin;
        int          amax;
        bit          found;
        if (!window_filled) begin
            for (int i = 0; i < WINDOW_POINTS; i++)
                alt_window[i] = alt;
            window_filled = 1'b1;
            wr_idx = 0;
        end
        lo = alt_window[0];
        hi = alt_window[0];
        for (int i = 1; i < WINDOW_POINTS; i++) begin
            if (alt_window[i] < lo) lo = alt_window[i];
            if (alt_window[i] > hi) hi = alt_window[i];
        end
        fifth = (hi - lo) / 5;
        tick  = 5;
        found = 1'b0;
        for (int i = 0; i < 8; i++) begin
            if (!found && fifth < nice_ticks[i]) begin
                tick  = nice_ticks[i];
                found = 1'b1;
            end
        end
        // int division truncates toward zero, as the axis needs
        amin = (lo / tick) * tick - tick;
        amax = amin + 5 * tick;
        r.window_min = lo[15:0];
        r.window_max = hi[15:0];
        r.tick_step  = tick[12:0];
        r.axis_min   = amin[16:0];
        r.axis_max   = amax[16:0];
        alt_window[wr_idx] = alt;
        wr_idx = (wr_idx + 1) % WINDOW_POINTS;
        return r;
    endfunction

    // called at a falling edge, returns at a falling edge
    task automatic offer_sample(input logic signed [SAMPLE_W-1:0] alt, input bit quiet,
                                input bit use_typed, input t_axis_scale typed_want);
        int          gap;
        t_axis_scale pred;
        gap = quiet ? 0 : $urandom_range(0, 8);
        if (gap != 0) begin
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = alt;
        do @(posedge i_clk); while (!s_axis_tready);
        pred = predict_axis(alt);
        expected_scales.push_back(use_typed ? typed_want : pred);
        @(negedge i_clk);
    endtask

    // result side
    initial begin
        int          stall;
        bit          steady;
        t_axis_scale got;
        t_axis_scale want;
        steady = 1'b0;
        while (!i_rst_n) @(negedge i_clk);
        forever begin
            if (results_seen % 64 == 0) steady = ($urandom_range(0, 3) == 0);
            stall = steady ? 0 : $urandom_range(0, 8);
            // long hold-off so the block backs up and stalls its input
            if (results_seen == 30 || results_seen == 500) stall = HOLD_OFF;
            if (stall != 0) begin
                m_axis_tready = 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            m_axis_tready = 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
            got = m_axis_tdata[78:0];
            results_seen++;
            if (expected_scales.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result %0d arrived with nothing expected", results_seen);
            end else begin
                want = expected_scales.pop_front();
                if (got.window_min !== want.window_min || got.window_max !== want.window_max ||
                    got.tick_step !== want.tick_step || got.axis_min !== want.axis_min ||
                    got.axis_max !== want.axis_max) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("result %0d: expected min %0d max %0d tick %0d axis %0d..%0d",
                                 results_seen, want.window_min, want.window_max,
                                 want.tick_step, want.axis_min, want.axis_max);
                        $display("result %0d:      got min %0d max %0d tick %0d axis %0d..%0d",
                                 results_seen, got.window_min, got.window_max,
                                 got.tick_step, got.axis_min, got.axis_max);
                    end
                end
            end
            @(negedge i_clk);
        end
    end

    // sample side
    initial begin
        int                         sent;
        int                         pick;
        int                         spread;
        int                         base;
        int                         ep_len;
        bit                         quiet;
        bit                         noisy;
        logic signed [SAMPLE_W-1:0] alt;
        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;

        for (int r = 0; r < DIR_ROWS; r++)
            offer_sample(dir_tab[r].alt, 1'b0, dir_tab[r].checked, dir_tab[r].want);

        // episodes of samples held within a chosen span (some with random outliers), so the window settles on it
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            pick = $urandom_range(0, 11);
            if (pick < 8)
                spread = span_steps[pick] - int'($urandom_range(0, 1));
            else if (pick == 8)
                spread = 0;
            else if (pick == 9)
                spread = 65535;
            else
                spread = $urandom_range(0, 65535);
            base   = int'($urandom_range(0, 65535 - spread)) - 32768;
            noisy  = ($urandom_range(0, 3) == 0);
            quiet  = ($urandom_range(0, 4) == 0);
            ep_len = $urandom_range(95, 140);
            for (int k = 0; k < ep_len && sent < RANDOM_ITEMS; k++) begin
                if (k == 0)
                    alt = SAMPLE_W'(base);
                else if (k == 1)
                    alt = SAMPLE_W'(base + spread);
                else if (noisy && $urandom_range(0, 9) == 0)
                    alt = SAMPLE_W'($urandom);
                else if ($urandom_range(0, 7) == 0)
                    alt = SAMPLE_W'($urandom_range(0, 1) ? base : base + spread);
                else
                    alt = SAMPLE_W'(base + int'($urandom_range(0, spread)));
                offer_sample(alt, quiet, 1'b0, '0);
                sent++;
            end
        end
        s_axis_tvalid = 1'b0;

        while (expected_scales.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (mismatches == 0)
            $display("window_autoscale_axis test passed");
        else
            $display("window_autoscale_axis test failed");
        $finish;
    end

endmodule
